>>> design/ogld_pkg.sv
// ----------------------------------------------------------------------------
// ogld_pkg
// Shared types and constants for the gateway line decoder: line store sizes,
// character codes, data IDs, variable numbers and the result record.
// ----------------------------------------------------------------------------
package ogld_pkg;

    localparam int LINE_MAX   = 40;
    localparam int KEPT_CHARS = 9;
    localparam int NUM_VARS   = 8;
    localparam int CNT_W      = 6;

    typedef logic [7:0]       t_char;
    typedef logic [CNT_W-1:0] t_count;
    typedef logic [3:0]       t_var;

    // source characters
    localparam t_char SRC_THERMOSTAT = 8'h54;
    localparam t_char SRC_BOILER     = 8'h42;
    localparam t_char CHAR_LF        = 8'h0A;

    // data IDs
    localparam logic [7:0] ID_STATUS      = 8'h00;
    localparam logic [7:0] ID_SETPOINT    = 8'h10;
    localparam logic [7:0] ID_MODULATION  = 8'h11;
    localparam logic [7:0] ID_PRESSURE    = 8'h12;
    localparam logic [7:0] ID_ROOM_TEMP   = 8'h18;
    localparam logic [7:0] ID_BOILER_TEMP = 8'h19;
    localparam logic [7:0] ID_RETURN_TEMP = 8'h1C;

    // status bits in the low data byte
    localparam int FLAME_BIT = 3;
    localparam int DHW_BIT   = 2;

    // variable numbers
    localparam t_var VAR_NONE        = 4'd0;
    localparam t_var VAR_ROOM_TEMP   = 4'd1;
    localparam t_var VAR_BOILER_TEMP = 4'd2;
    localparam t_var VAR_MODULATION  = 4'd3;
    localparam t_var VAR_PRESSURE    = 4'd4;
    localparam t_var VAR_SETPOINT    = 4'd5;
    localparam t_var VAR_FLAME       = 4'd6;
    localparam t_var VAR_RETURN_TEMP = 4'd7;
    localparam t_var VAR_DHW         = 4'd8;

    localparam logic [15:0] FLAG_ON = 16'h0100;

    typedef struct packed {
        t_var        variable_index;
        logic [15:0] value_fixed;
        logic        changed;
        logic [31:0] message_word;
        logic        last;
    } t_result;

    // decoder output for one completed line
    typedef struct packed {
        logic [1:0]  nres;
        t_var        var0;
        logic [15:0] val0;
        t_var        var1;
        logic [15:0] val1;
        logic [31:0] word;
    } t_dec;

endpackage

>>> design/opentherm_gateway_line_decoder_unit.sv
// ----------------------------------------------------------------------------
// opentherm_gateway_line_decoder_unit
// Collects gateway serial bytes into a line and, at each line feed, emits the
// variable updates of the line with a change flag per variable.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_rx_byte
//  result   out        o_valid / i_stall  o_variable_index, o_value_fixed,
//                                         o_changed, o_message_word, o_last
//
//  one request accepted per cycle unless o_stall is high; each request is
//  registered, then its results enter the result buffer; a boiler status line
//  gives two results, flame then hot water, and holds the result port for both
//  two-entry result buffer; input stalls only when it cannot take the results
//  synchronous active-low reset clears line store, count, last words, empties buffer
// ----------------------------------------------------------------------------
module opentherm_gateway_line_decoder_unit
    import ogld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_variable_index,
    output logic [15:0] o_value_fixed,
    output logic        o_changed,
    output logic [31:0] o_message_word,
    output logic        o_last
);

    logic        r_in_valid;
    t_char       r_in_byte;
    t_char       r_line [KEPT_CHARS];
    t_count      r_count;
    logic [31:0] r_prev [NUM_VARS];
    t_result     r_q0, r_q1;
    logic [1:0]  r_qcnt;

    t_char          eff_chars [KEPT_CHARS];
    t_dec           dec;
    logic           is_lf, is_alnum, store;
    logic           pop, fire;
    logic [1:0]     cnt_after, need;
    logic [NUM_VARS-1:0] diff;
    t_result        res0, res1;
    logic [1:0]     n_qcnt;
    t_result        n_q0, n_q1;

    // line as seen at line feed: position at the count reads as zero
    always_comb begin
        for (int i = 0; i < KEPT_CHARS; i++) begin
            eff_chars[i] = (r_count == t_count'(i)) ? 8'h00 : r_line[i];
        end
    end

    ogld_decode u_decode (
        .i_chars (eff_chars),
        .o_dec   (dec)
    );

    always_comb begin
        is_lf    = (r_in_byte == CHAR_LF);
        is_alnum = (r_in_byte >= 8'h30 && r_in_byte <= 8'h39) ||
                   (r_in_byte >= 8'h41 && r_in_byte <= 8'h5A) ||
                   (r_in_byte >= 8'h61 && r_in_byte <= 8'h7A);
        store    = is_alnum && (r_count < t_count'(LINE_MAX));

        pop       = o_valid && !i_stall;
        cnt_after = r_qcnt - {1'b0, pop};
        need      = is_lf ? dec.nres : 2'd0;
        fire      = r_in_valid && (need <= 2'd2 - cnt_after);

        for (int k = 0; k < NUM_VARS; k++) begin
            diff[k] = (r_prev[k] != dec.word);
        end

        res0.variable_index = dec.var0;
        res0.value_fixed    = dec.val0;
        res0.changed        = diff[3'(dec.var0 - 4'd1)];
        res0.message_word   = dec.word;
        res0.last           = (need == 2'd1);

        res1.variable_index = dec.var1;
        res1.value_fixed    = dec.val1;
        res1.changed        = diff[3'(dec.var1 - 4'd1)];
        res1.message_word   = dec.word;
        res1.last           = 1'b1;

        // pop first, then append the new results behind what remains
        n_q0 = pop ? r_q1 : r_q0;
        n_q1 = r_q1;
        if (fire && need != 2'd0) begin
            if (cnt_after == 2'd0) begin
                n_q0 = res0;
                n_q1 = res1;
            end else begin
                n_q1 = res0;
            end
        end
        n_qcnt = cnt_after + (fire ? need : 2'd0);
    end

    assign o_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < KEPT_CHARS; i++) begin
                r_line[i] <= '0;
            end
        end else if (fire) begin
            if (store) begin
                if (r_count < t_count'(KEPT_CHARS)) begin
                    r_line[r_count[3:0]] <= r_in_byte;
                end
                r_count <= r_count + t_count'(1);
            end else if (is_lf) begin
                if (r_count < t_count'(KEPT_CHARS)) begin
                    r_line[r_count[3:0]] <= 8'h00;
                end
                r_line[0] <= 8'h00;
                r_count   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_VARS; k++) begin
                r_prev[k] <= '0;
            end
        end else if (fire && need != 2'd0) begin
            for (int k = 0; k < NUM_VARS; k++) begin
                if (dec.var0 == t_var'(k + 1) ||
                    (need == 2'd2 && dec.var1 == t_var'(k + 1))) begin
                    r_prev[k] <= dec.word;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= '0;
        end else begin
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_valid          = (r_qcnt != 2'd0);
    assign o_variable_index = r_q0.variable_index;
    assign o_value_fixed    = r_q0.value_fixed;
    assign o_changed        = r_q0.changed;
    assign o_message_word   = r_q0.message_word;
    assign o_last           = r_q0.last;

    a_qcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt != 2'd3)
        else $error("result buffer over two entries");

    a_lf_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_lf) |=> (r_count == '0))
        else $error("line count not cleared after line feed");

    a_flame_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_variable_index == VAR_FLAME) |-> (!o_last && r_qcnt == 2'd2))
        else $error("flame result without hot-water result behind it");

endmodule

>>> design/ogld_decode.sv
// ----------------------------------------------------------------------------
// ogld_decode
// Decodes a completed line: source character, four hex bytes, data ID lookup
// and the values of up to two variable updates.
// ----------------------------------------------------------------------------
module ogld_decode
    import ogld_pkg::*;
(
    input  t_char i_chars [KEPT_CHARS],
    output t_dec  o_dec
);

    // no range check on the digit, matching the line format loosely
    function automatic logic [7:0] hex_digit(input t_char c);
        logic [7:0] d;
        d = c - 8'h30;
        if (d > 8'd16) begin
            d = d - 8'd7;
        end
        return d;
    endfunction

    function automatic logic [7:0] hex_pair(input t_char hi, input t_char lo);
        logic [7:0] h;
        logic [7:0] l;
        h = hex_digit(hi);
        l = hex_digit(lo);
        return {h[3:0], 4'b0000} + l;
    endfunction

    logic [7:0] b1, b2, b3, b4;
    t_char      source;

    always_comb begin
        source = i_chars[0];
        b1     = hex_pair(i_chars[1], i_chars[2]);
        b2     = hex_pair(i_chars[3], i_chars[4]);
        b3     = hex_pair(i_chars[5], i_chars[6]);
        b4     = hex_pair(i_chars[7], i_chars[8]);

        o_dec      = '0;
        o_dec.word = {b1, b2, b3, b4};
        o_dec.val0 = {b3, b4};
        o_dec.var0 = VAR_NONE;
        o_dec.var1 = VAR_DHW;
        o_dec.val1 = b4[DHW_BIT] ? FLAG_ON : 16'h0000;

        if (source == SRC_THERMOSTAT) begin
            case (b2)
                ID_ROOM_TEMP: o_dec.var0 = VAR_ROOM_TEMP;
                ID_SETPOINT:  o_dec.var0 = VAR_SETPOINT;
                default:      o_dec.var0 = VAR_NONE;
            endcase
        end else if (source == SRC_BOILER) begin
            case (b2)
                ID_BOILER_TEMP: o_dec.var0 = VAR_BOILER_TEMP;
                ID_MODULATION:  o_dec.var0 = VAR_MODULATION;
                ID_PRESSURE:    o_dec.var0 = VAR_PRESSURE;
                ID_RETURN_TEMP: o_dec.var0 = VAR_RETURN_TEMP;
                ID_STATUS: begin
                    o_dec.var0 = VAR_FLAME;
                    o_dec.val0 = b4[FLAME_BIT] ? FLAG_ON : 16'h0000;
                end
                default:        o_dec.var0 = VAR_NONE;
            endcase
        end

        if (o_dec.var0 == VAR_FLAME) begin
            o_dec.nres = 2'd2;
        end else if (o_dec.var0 != VAR_NONE) begin
            o_dec.nres = 2'd1;
        end else begin
            o_dec.nres = 2'd0;
        end
    end

endmodule

>>> tb/sv/opentherm_gateway_line_decoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// opentherm_gateway_line_decoder_unit_test
// Sends gateway text lines to the line decoder one byte per request, with
// random gaps on the input and random stalls on the result side. Each line
// feed is decoded by a predictor in the bench, and every variable update is
// checked field by field in order. A short directed table comes first, then
// random lines, repeated messages, overlong lines and noise.
// ----------------------------------------------------------------------------
module opentherm_gateway_line_decoder_unit_test;
    import ogld_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int ITEM_TARGET  = 1700;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 16;
    localparam int NUM_ROWS     = 24;
    localparam int PRINT_CAP    = 100;

    localparam t_char CHAR_CR = 8'h0D;

    typedef struct packed {
        t_char      ch;
        logic       typed;
        logic [1:0] n_res;
        t_result    r0;
        t_result    r1;
    } t_stim_row;

    localparam t_result NO_RES = '0;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_variable_index;
    logic [15:0] o_value_fixed;
    logic        o_changed;
    logic [31:0] o_message_word;
    logic        o_last;

    // predictor state
    t_char       line_store [KEPT_CHARS];
    t_count      held_count;
    logic [31:0] last_word [NUM_VARS];

    t_result   pending_updates [$];
    t_char     line_bytes [$];
    t_stim_row stim_rows [NUM_ROWS];

    // message reused for repeated lines
    t_char       msg_src;
    logic [31:0] msg_word;
    logic        msg_lower;
    logic        have_msg = 1'b0;

    int   errors         = 0;
    int   results_seen   = 0;
    int   unchanged_seen = 0;
    int   bytes_sent     = 0;
    int   items_counted  = 0;
    int   lines_sent     = 0;
    int   cycle_count    = 0;
    logic hold_off       = 1'b0;

    opentherm_gateway_line_decoder_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_variable_index (o_variable_index),
        .o_value_fixed    (o_value_fixed),
        .o_changed        (o_changed),
        .o_message_word   (o_message_word),
        .o_last           (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic is_alnum(input t_char c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [7:0] hex_value(input t_char c);
        logic [7:0] d;
        d = c - 8'h30;
        if (d > 8'd16) d = d - 8'd7;
        return d;
    endfunction

    function automatic logic [7:0] hex_byte(input int pos);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = hex_value(line_store[pos]);
        lo = hex_value(line_store[pos + 1]);
        return {hi[3:0], 4'h0} + lo;
    endfunction

    function automatic t_result record_update(input t_var v, input logic [15:0] value,
                                              input logic [31:0] word);
        t_result r;
        r.variable_index = v;
        r.value_fixed    = value;
        r.changed        = (last_word[3'(v - 4'd1)] != word);
        r.message_word   = word;
        r.last           = 1'b0;
        last_word[3'(v - 4'd1)] = word;
        return r;
    endfunction

    // advances the line store by one byte, returns the number of updates
    function automatic int predict_line_byte(input t_char c, output t_result r0,
                                             output t_result r1);
        t_var        v;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [31:0] word;
        int          n;
        n  = 0;
        v  = VAR_NONE;
        r0 = NO_RES;
        r1 = NO_RES;
        if (int'(held_count) < LINE_MAX && is_alnum(c)) begin
            if (held_count < KEPT_CHARS) line_store[held_count[3:0]] = c;
            held_count = held_count + 1'b1;
        end
        if (c == CHAR_LF) begin
            // positions past the count keep characters of earlier lines
            if (held_count < KEPT_CHARS) line_store[held_count[3:0]] = 8'h00;
            b1   = hex_byte(1);
            b2   = hex_byte(3);
            b3   = hex_byte(5);
            b4   = hex_byte(7);
            word = {b1, b2, b3, b4};
            if (line_store[0] == SRC_THERMOSTAT) begin
                if (b2 == ID_ROOM_TEMP) v = VAR_ROOM_TEMP;
                else if (b2 == ID_SETPOINT) v = VAR_SETPOINT;
            end else if (line_store[0] == SRC_BOILER) begin
                case (b2)
                    ID_BOILER_TEMP: v = VAR_BOILER_TEMP;
                    ID_MODULATION:  v = VAR_MODULATION;
                    ID_PRESSURE:    v = VAR_PRESSURE;
                    ID_RETURN_TEMP: v = VAR_RETURN_TEMP;
                    ID_STATUS: begin
                        r0 = record_update(VAR_FLAME, b4[FLAME_BIT] ? FLAG_ON : 16'h0000, word);
                        r1 = record_update(VAR_DHW, b4[DHW_BIT] ? FLAG_ON : 16'h0000, word);
                        r1.last = 1'b1;
                        n = 2;
                    end
                    default: ;
                endcase
            end
            if (v != VAR_NONE) begin
                r0 = record_update(v, {b3, b4}, word);
                r0.last = 1'b1;
                n = 1;
            end
            line_store[0] = 8'h00;
            held_count    = '0;
        end
        return n;
    endfunction

    function automatic int pick_gap(input logic quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_char rand_alnum();
        int k;
        k = $urandom_range(0, 61);
        if (k < 10) return t_char'(8'h30 + k);
        if (k < 36) return t_char'(8'h41 + k - 10);
        return t_char'(8'h61 + k - 36);
    endfunction

    function automatic logic [7:0] pool_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'h04;
            2:       return 8'h08;
            3:       return 8'h0C;
            4:       return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic t_char hex_char(input logic [3:0] nib, input logic lower);
        if (nib < 4'd10) return t_char'(8'h30 + nib);
        return t_char'((lower ? 8'h61 : 8'h41) + nib - 8'd10);
    endfunction

    // optionally slips an ignored byte in front of the character
    function automatic void push_char(input t_char c, input logic sloppy);
        t_char junk;
        if (sloppy && $urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                junk = CHAR_CR;
            end else begin
                do junk = t_char'($urandom_range(0, 255));
                while (is_alnum(junk) || junk == CHAR_LF);
            end
            line_bytes.push_back(junk);
        end
        line_bytes.push_back(c);
    endfunction

    function automatic void build_message(input int extra);
        logic [7:0] id;
        logic       sloppy;
        int         pick;
        // mostly fresh messages, some repeats so unchanged words show up
        if (!have_msg || $urandom_range(0, 4) != 0) begin
            pick    = $urandom_range(0, 99);
            msg_src = (pick < 45) ? SRC_THERMOSTAT : (pick < 90) ? SRC_BOILER : rand_alnum();
            if ($urandom_range(0, 99) < 85) begin
                if (msg_src == SRC_THERMOSTAT) begin
                    id = $urandom_range(0, 1) ? ID_ROOM_TEMP : ID_SETPOINT;
                end else begin
                    case ($urandom_range(0, 4))
                        0:       id = ID_BOILER_TEMP;
                        1:       id = ID_MODULATION;
                        2:       id = ID_PRESSURE;
                        3:       id = ID_RETURN_TEMP;
                        default: id = ID_STATUS;
                    endcase
                end
            end else begin
                id = 8'($urandom_range(0, 255));
            end
            msg_word[31:24] = $urandom_range(0, 1) ? pool_byte() : 8'($urandom_range(0, 255));
            msg_word[23:16] = id;
            msg_word[15:8]  = $urandom_range(0, 1) ? pool_byte() : 8'($urandom_range(0, 255));
            msg_word[7:0]   = $urandom_range(0, 1) ? pool_byte() : 8'($urandom_range(0, 255));
            msg_lower       = ($urandom_range(0, 9) == 0);
            have_msg        = 1'b1;
        end
        sloppy = ($urandom_range(0, 3) == 0);
        push_char(msg_src, sloppy);
        for (int k = 7; k >= 0; k--) push_char(hex_char(msg_word[4*k +: 4], msg_lower), sloppy);
        repeat (extra) push_char(rand_alnum(), sloppy);
        if ($urandom_range(0, 4) == 0) line_bytes.push_back(CHAR_CR);
        line_bytes.push_back(CHAR_LF);
    endfunction

    task automatic send_byte(input t_char c, input logic typed, input logic [1:0] n_typed,
                             input t_result r0_typed, input t_result r1_typed,
                             input int gap);
        t_result r0;
        t_result r1;
        int      n;
        i_valid   <= 1'b1;
        i_rx_byte <= c;
        do @(posedge i_clk); while (o_stall);
        n = predict_line_byte(c, r0, r1);
        if (typed) begin
            n  = n_typed;
            r0 = r0_typed;
            r1 = r1_typed;
        end
        if (n >= 1) pending_updates.push_back(r0);
        if (n == 2) pending_updates.push_back(r1);
        bytes_sent++;
        if (is_alnum(c) || c == CHAR_LF) items_counted++;
        if (c == CHAR_LF) lines_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at update %0d: %s got %h want %h", results_seen, what, got, want);
    endtask

    // stimulus
    initial begin
        logic quiet;
        int   n;
        int   gap;
        gap = 0;
        for (int k = 0; k < KEPT_CHARS; k++) line_store[k] = 8'h00;
        for (int k = 0; k < NUM_VARS; k++) last_word[k] = 32'h0;
        held_count = '0;

        stim_rows = '{
            '{8'h00,          1'b0, 2'd0, NO_RES, NO_RES},
            // empty line right after reset
            '{CHAR_LF,        1'b1, 2'd0, NO_RES, NO_RES},
            '{SRC_BOILER,     1'b0, 2'd0, NO_RES, NO_RES},
            '{"4",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"0",            1'b0, 2'd0, NO_RES, NO_RES},
            '{CHAR_CR,        1'b0, 2'd0, NO_RES, NO_RES},
            '{"0",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"0",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"0",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"0",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"0",            1'b0, 2'd0, NO_RES, NO_RES},
            '{8'hFF,          1'b0, 2'd0, NO_RES, NO_RES},
            '{"C",            1'b0, 2'd0, NO_RES, NO_RES},
            // boiler status with flame and hot water both on
            '{CHAR_LF,        1'b1, 2'd2,
              '{VAR_FLAME, FLAG_ON, 1'b1, 32'h4000000C, 1'b0},
              '{VAR_DHW,   FLAG_ON, 1'b1, 32'h4000000C, 1'b1}},
            '{SRC_THERMOSTAT, 1'b0, 2'd0, NO_RES, NO_RES},
            '{"0",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"0",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"1",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"8",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"F",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"F",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"F",            1'b0, 2'd0, NO_RES, NO_RES},
            '{"F",            1'b0, 2'd0, NO_RES, NO_RES},
            // room temperature at full scale
            '{CHAR_LF,        1'b1, 2'd1,
              '{VAR_ROOM_TEMP, 16'hFFFF, 1'b1, 32'h0018FFFF, 1'b1}, NO_RES}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < NUM_ROWS; row++) begin
            gap = pick_gap(1'b0);
            send_byte(stim_rows[row].ch, stim_rows[row].typed, stim_rows[row].n_res,
                      stim_rows[row].r0, stim_rows[row].r1, gap);
        end

        while (items_counted < ITEM_TARGET) begin
            line_bytes.delete();
            n = $urandom_range(0, 99);
            if (n < 65) begin
                build_message(($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0);
            end else if (n < 75) begin
                // reaches or runs past the line limit
                build_message($urandom_range(31, 45));
            end else if (n < 87) begin
                // short line, tail comes from earlier lines
                n = $urandom_range(0, 8);
                for (int k = 0; k < n; k++) begin
                    if (k == 0 && $urandom_range(0, 1))
                        line_bytes.push_back($urandom_range(0, 1) ? SRC_BOILER : SRC_THERMOSTAT);
                    else
                        line_bytes.push_back(rand_alnum());
                end
                line_bytes.push_back(CHAR_LF);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) line_bytes.push_back(t_char'($urandom_range(0, 255)));
            end
            quiet = ($urandom_range(0, 3) == 0);
            foreach (line_bytes[k]) begin
                gap = pick_gap(quiet);
                send_byte(line_bytes[k], 1'b0, 2'd0, NO_RES, NO_RES, gap);
            end
        end
        // a nonzero last gap has already dropped valid
        if (gap == 0) i_valid <= 1'b0;

        wait (pending_updates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d bytes (%0d letters, digits and line feeds) in %0d lines",
                 bytes_sent, items_counted, lines_sent);
        $display("%0d variable updates checked, %0d unchanged, %0d mismatches",
                 results_seen, unchanged_seen, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // result side: checks and random stalls
    initial begin
        t_result want;
        int      stall_left;
        int      mode_left;
        logic    quiet;
        stall_left = 0;
        mode_left  = 0;
        quiet      = 1'b0;
        wait (i_rst_n == 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (pending_updates.size() == 0) begin
                    report_mismatch("update with none pending, word", o_message_word, 32'h0);
                end else begin
                    want = pending_updates.pop_front();
                    if (o_variable_index !== want.variable_index)
                        report_mismatch("variable_index", o_variable_index, want.variable_index);
                    if (o_value_fixed !== want.value_fixed)
                        report_mismatch("value_fixed", o_value_fixed, want.value_fixed);
                    if (o_changed !== want.changed)
                        report_mismatch("changed", o_changed, want.changed);
                    if (o_message_word !== want.message_word)
                        report_mismatch("message_word", o_message_word, want.message_word);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                end
                results_seen++;
                if (o_changed === 1'b0) unchanged_seen++;
            end
            if (mode_left == 0) begin
                quiet     = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(32, 128);
            end else begin
                mode_left--;
            end
            if (hold_off) begin
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 99) < 30) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // long hold-off so the result buffer fills and the input backs up
    initial begin
        wait (results_seen >= 40);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d updates pending",
                 cycle_count, pending_updates.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
design/ogld_pkg.sv
design/ogld_decode.sv
design/opentherm_gateway_line_decoder_unit.sv
tb/sv/opentherm_gateway_line_decoder_unit_test.sv
